### sv/cms_pkg.sv
`timescale 1ns / 1ps
package cms_pkg;

  // width of the level count carried with every word
  localparam int LVL_W = 3;

  // per-stage history count
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_MANY = 2'd2;

  // bit positions of the pending-output mask in a stage, in emission order
  localparam int SEL_MM = 0;  // midpoint of two midpoints
  localparam int SEL_M  = 1;  // midpoint of held point and new point
  localparam int SEL_P  = 2;  // the point itself

endpackage

### sv/cms_fifo.sv
`timescale 1ns / 1ps
module cms_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [AW:0]  wr_r, wr_nxt;
  logic [AW:0]  rd_r, rd_nxt;
  logic [AW:0]  cnt;

  // occupancy from pointer distance; DEPTH is a power of two
  assign cnt   = wr_r - rd_r;
  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem_r[rd_r[AW-1:0]];

  assign wr_nxt = (push && !full) ? wr_r + 1'b1 : wr_r;
  assign rd_nxt = (pop && !empty) ? rd_r + 1'b1 : rd_r;

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_r[AW-1:0]] <= din;
    end
  end

endmodule

### sv/cms_front.sv
`timescale 1ns / 1ps
module cms_front #(
  parameter int MAX_LEVELS = 5,
  parameter int CW         = 16,
  parameter int QDEPTH     = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cms_pkg::LVL_W-1:0] cfg_levels,
  input  logic                      push,
  output logic                      full,
  input  logic [CW-1:0]             in_x,
  input  logic [CW-1:0]             in_y,
  input  logic                      in_last,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic [CW-1:0]             q_x,
  output logic [CW-1:0]             q_y,
  output logic                      q_last,
  output logic [cms_pkg::LVL_W-1:0] q_act
);
  import cms_pkg::*;

  localparam int QW = 2*CW + 1 + LVL_W;

  logic [LVL_W-1:0] levels_r, levels_nxt;
  logic [LVL_W-1:0] act;
  logic [QW-1:0]    q_din, q_dout;
  logic             q_empty;

  // levels register
  assign levels_nxt = cfg_we ? cfg_levels : levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LVL_W'(1);
    end else begin
      levels_r <= levels_nxt;
    end
  end

  // classify: stage count tagged onto each word, saturated to the built depth
  assign act   = (levels_r > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels_r;
  assign q_din = {act, in_last, in_y, in_x};

  cms_fifo #(.W(QW), .DEPTH(QDEPTH)) u_inq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .din   (q_din),
    .pop   (q_ready),
    .empty (q_empty),
    .dout  (q_dout)
  );

  assign q_valid = !q_empty;
  assign q_x     = q_dout[CW-1:0];
  assign q_y     = q_dout[2*CW-1:CW];
  assign q_last  = q_dout[2*CW];
  assign q_act   = q_dout[QW-1:2*CW+1];

endmodule

### sv/cms_stage.sv
`timescale 1ns / 1ps
module cms_stage #(
  parameter int CW  = 16,
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CW-1:0]             in_x,
  input  logic [CW-1:0]             in_y,
  input  logic                      in_last,
  input  logic [cms_pkg::LVL_W-1:0] in_act,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CW-1:0]             out_x,
  output logic [CW-1:0]             out_y,
  output logic                      out_last,
  output logic [cms_pkg::LVL_W-1:0] out_act
);
  import cms_pkg::*;

  // floor((a+b)/2) on signed values
  function automatic logic [CW-1:0] mid(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    return s[CW:1];
  endfunction

  logic [1:0]       seen_r, seen_nxt;
  logic [2:0]       mask_r, mask_nxt;
  logic [CW-1:0]    hp_x_r, hp_x_nxt, hp_y_r, hp_y_nxt;
  logic [CW-1:0]    hm_x_r, hm_x_nxt, hm_y_r, hm_y_nxt;
  logic [CW-1:0]    mm_x_r, mm_x_nxt, mm_y_r, mm_y_nxt;
  logic [CW-1:0]    m_x_r, m_x_nxt, m_y_r, m_y_nxt;
  logic [CW-1:0]    p_x_r, p_x_nxt, p_y_r, p_y_nxt;
  logic             last_r, last_nxt;
  logic [LVL_W-1:0] act_r, act_nxt;

  logic          pop, acc, hit;
  logic [2:0]    mask_left;
  logic [CW-1:0] m_x, m_y;

  // output side: the mask holds the words still owed for the current point
  assign out_valid = (mask_r != 3'b000);
  assign pop       = out_valid && out_ready;
  assign mask_left = mask_r & (mask_r - 3'd1);
  assign in_ready  = (mask_r == 3'b000) || (pop && mask_left == 3'b000);
  assign acc       = in_valid && in_ready;
  assign hit       = (in_act > LVL_W'(IDX));

  assign m_x = mid(hp_x_r, in_x);
  assign m_y = mid(hp_y_r, in_y);

  // word select, oldest first
  always_comb begin
    out_act = act_r;
    if (mask_r[SEL_MM]) begin
      out_x    = mm_x_r;
      out_y    = mm_y_r;
      out_last = 1'b0;
    end else if (mask_r[SEL_M]) begin
      out_x    = m_x_r;
      out_y    = m_y_r;
      out_last = 1'b0;
    end else begin
      out_x    = p_x_r;
      out_y    = p_y_r;
      out_last = last_r;
    end
  end

  // accept a point and update the stage history
  always_comb begin
    seen_nxt = seen_r;
    mask_nxt = pop ? mask_left : mask_r;
    hp_x_nxt = hp_x_r;
    hp_y_nxt = hp_y_r;
    hm_x_nxt = hm_x_r;
    hm_y_nxt = hm_y_r;
    mm_x_nxt = mm_x_r;
    mm_y_nxt = mm_y_r;
    m_x_nxt  = m_x_r;
    m_y_nxt  = m_y_r;
    p_x_nxt  = p_x_r;
    p_y_nxt  = p_y_r;
    last_nxt = last_r;
    act_nxt  = act_r;
    if (acc) begin
      p_x_nxt  = in_x;
      p_y_nxt  = in_y;
      last_nxt = in_last;
      act_nxt  = in_act;
      m_x_nxt  = m_x;
      m_y_nxt  = m_y;
      mm_x_nxt = mid(hm_x_r, m_x);
      mm_y_nxt = mid(hm_y_r, m_y);
      if (!hit) begin
        // stage not in use for this word: pass through, history untouched
        mask_nxt = 3'b100;
      end else if (seen_r == SEEN_NONE) begin
        mask_nxt = 3'b100;
        if (!in_last) begin
          hp_x_nxt = in_x;
          hp_y_nxt = in_y;
          seen_nxt = SEEN_ONE;
        end
      end else begin
        mask_nxt = {in_last, 1'b1, seen_r == SEEN_MANY};
        hm_x_nxt = m_x;
        hm_y_nxt = m_y;
        hp_x_nxt = in_x;
        hp_y_nxt = in_y;
        seen_nxt = in_last ? SEEN_NONE : SEEN_MANY;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= SEEN_NONE;
      mask_r <= 3'b000;
    end else begin
      seen_r <= seen_nxt;
      mask_r <= mask_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    hp_x_r <= hp_x_nxt;
    hp_y_r <= hp_y_nxt;
    hm_x_r <= hm_x_nxt;
    hm_y_r <= hm_y_nxt;
    mm_x_r <= mm_x_nxt;
    mm_y_r <= mm_y_nxt;
    m_x_r  <= m_x_nxt;
    m_y_r  <= m_y_nxt;
    p_x_r  <= p_x_nxt;
    p_y_r  <= p_y_nxt;
    last_r <= last_nxt;
    act_r  <= act_nxt;
  end

  // a midpoint of midpoints is always followed by its midpoint
  a_mm_then_m: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r[SEL_MM] |-> mask_r[SEL_M])
    else $error("stage: mm word pending without m word");

  // history count never takes the unused code
  a_seen_code: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 2'd3)
    else $error("stage: bad history count");

  // a flagged point closes the list in an active stage
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && hit && in_last) |=> (seen_r == SEEN_NONE))
    else $error("stage: history not cleared on last point");

  // a pass-through word leaves the history alone
  a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !hit) |=> $stable(seen_r))
    else $error("stage: history changed on pass-through word");

endmodule

### sv/cms_back.sv
`timescale 1ns / 1ps
module cms_back #(
  parameter int MAX_LEVELS = 5,
  parameter int CW         = 16,
  parameter int QDEPTH     = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  logic [CW-1:0]             q_x,
  input  logic [CW-1:0]             q_y,
  input  logic                      q_last,
  input  logic [cms_pkg::LVL_W-1:0] q_act,
  output logic                      empty,
  input  logic                      pop,
  output logic [CW-1:0]             res_x,
  output logic [CW-1:0]             res_y,
  output logic                      res_last
);
  import cms_pkg::*;

  localparam int RW = 2*CW + 1;

  logic             lv_valid [MAX_LEVELS+1];
  logic             lv_ready [MAX_LEVELS+1];
  logic [CW-1:0]    lv_x     [MAX_LEVELS+1];
  logic [CW-1:0]    lv_y     [MAX_LEVELS+1];
  logic             lv_last  [MAX_LEVELS+1];
  logic [LVL_W-1:0] lv_act   [MAX_LEVELS+1];

  logic          res_full;
  logic [RW-1:0] res_din, res_dout;

  // chain head
  assign lv_valid[0] = q_valid;
  assign q_ready     = lv_ready[0];
  assign lv_x[0]     = q_x;
  assign lv_y[0]     = q_y;
  assign lv_last[0]  = q_last;
  assign lv_act[0]   = q_act;

  // cascaded subdivision stages
  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_stage
    cms_stage #(.CW(CW), .IDX(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lv_valid[i]),
      .in_ready  (lv_ready[i]),
      .in_x      (lv_x[i]),
      .in_y      (lv_y[i]),
      .in_last   (lv_last[i]),
      .in_act    (lv_act[i]),
      .out_valid (lv_valid[i+1]),
      .out_ready (lv_ready[i+1]),
      .out_x     (lv_x[i+1]),
      .out_y     (lv_y[i+1]),
      .out_last  (lv_last[i+1]),
      .out_act   (lv_act[i+1])
    );
  end

  // result queue
  assign lv_ready[MAX_LEVELS] = !res_full;
  assign res_din = {lv_last[MAX_LEVELS], lv_y[MAX_LEVELS], lv_x[MAX_LEVELS]};

  cms_fifo #(.W(RW), .DEPTH(QDEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (lv_valid[MAX_LEVELS]),
    .full  (res_full),
    .din   (res_din),
    .pop   (pop),
    .empty (empty),
    .dout  (res_dout)
  );

  assign res_x    = res_dout[CW-1:0];
  assign res_y    = res_dout[2*CW-1:CW];
  assign res_last = res_dout[2*CW];

endmodule

### sv/curve_midpoint_subdivider_top.sv
`timescale 1ns / 1ps
// Midpoint corner-cutting curve subdivider. Control points go in as queue
// words (push/full) and curve points come out as queue words (empty/pop);
// a word with the last flag closes a list. cfg_levels selects 0..MAX_LEVELS
// cascaded passes (larger values saturate) and is sampled when a point is
// accepted. Every pass emits at most three words per incoming word, one per
// cycle while its downstream side is ready; the result port delivers one
// word per cycle while pop is held and the queue holds words. Once the
// chain is busy, the last stage's word rate and the result queue set the
// output rate. An input queue in front lets new points be taken while
// earlier ones are still being expanded; an output queue holds finished
// words. Each word passes the input queue, all MAX_LEVELS stages and the
// result queue whatever the level setting, since unused stages still
// register each word on its way through. No clearing pass follows reset.
module curve_midpoint_subdivider_top #(
  parameter int MAX_LEVELS = 5,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cms_pkg::LVL_W-1:0]    cfg_levels,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_last_point,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_last
);
  import cms_pkg::*;

  logic                  q_valid, q_ready, q_last;
  logic [COORD_BITS-1:0] q_x, q_y;
  logic [LVL_W-1:0]      q_act;
  logic [COORD_BITS-1:0] res_x, res_y;

  // front: config, level tagging, input queue
  cms_front #(.MAX_LEVELS(MAX_LEVELS), .CW(COORD_BITS), .QDEPTH(4)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_levels (cfg_levels),
    .push       (push),
    .full       (full),
    .in_x       (in_point_x),
    .in_y       (in_point_y),
    .in_last    (in_last_point),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_x        (q_x),
    .q_y        (q_y),
    .q_last     (q_last),
    .q_act      (q_act)
  );

  // back: subdivision stages and result queue
  cms_back #(.MAX_LEVELS(MAX_LEVELS), .CW(COORD_BITS), .QDEPTH(4)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_last   (q_last),
    .q_act    (q_act),
    .empty    (empty),
    .pop      (pop),
    .res_x    (res_x),
    .res_y    (res_y),
    .res_last (out_last)
  );

  assign out_x = res_x;
  assign out_y = res_y;

endmodule
